>>> src/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg: shared types and constants for the angle/bias Kalman filter
// Fixed-point formats, register indexes, sequencer states and unit opcodes.
// ----------------------------------------------------------------------------
package kaf_pkg;

    localparam int FRAC_BITS = 24;
    localparam int REG_W     = 31;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_BIAS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 2'd3;

    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(64'd1 << FRAC_BITS);

    // Divider: 32-bit signed numerator shifted by FRAC_BITS over a 33-bit
    // divisor; the quotient magnitude is developed one bit per cycle.
    localparam int DIV_NUM_W = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } kaf_op_t;

    typedef struct packed {
        logic                start;
        kaf_op_t             op;
        logic signed [32:0]  a;
        logic signed [32:0]  b;
    } kaf_req_t;

    typedef struct packed {
        logic                done;
        logic signed [63:0]  result;
    } kaf_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRED_A,
        ST_PRED_P00,
        ST_PRED_P01,
        ST_PRED_P11,
        ST_DIV_K0,
        ST_DIV_K1,
        ST_UPD_00,
        ST_UPD_01,
        ST_UPD_10,
        ST_UPD_11,
        ST_UPD_A,
        ST_UPD_B,
        ST_OUT
    } kaf_state_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

>>> src/kaf_arith.sv
// ----------------------------------------------------------------------------
// kaf_arith: shared multiply / divide unit
// Signed 33x33 multiply with rounding and a registered result, or a
// restoring divide one quotient bit per cycle with truncation to zero.
// ----------------------------------------------------------------------------
module kaf_arith (
    input  logic              aclk,
    input  logic              aresetn,
    input  kaf_pkg::kaf_req_t req,
    output kaf_pkg::kaf_rsp_t rsp
);
    import kaf_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic                 neg_reg,   neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg,   quo_next;
    logic [33:0]          rem_reg,   rem_next;
    logic [32:0]          den_reg,   den_next;
    logic signed [63:0]   res_reg,   res_next;

    logic signed [65:0]   prod;
    logic [33:0]          trial;
    logic [31:0]          num_mag;
    logic [32:0]          den_mag;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        res_next  = res_reg;
        prod      = 66'(req.a) * 66'(req.b);
        num_mag   = req.a[31] ? 32'(-req.a) : req.a[31:0];
        den_mag   = req.b[32] ? 33'(-req.b) : req.b[32:0];
        trial     = {rem_reg[32:0], quo_reg[DIV_NUM_W-1]} - {1'b0, den_reg};
        if (req.start && !busy_reg) begin
            case (req.op)
                OP_MUL: begin
                    // round half up, floor shift
                    res_next  = 64'((prod + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
                    done_next = 1'b1;
                end
                OP_DIV: begin
                    if (req.b == '0) begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end else begin
                        busy_next = 1'b1;
                        neg_next  = req.a[31] ^ req.b[32];
                        quo_next  = {num_mag, {FRAC_BITS{1'b0}}};
                        rem_next  = '0;
                        den_next  = den_mag;
                        cnt_next  = DIV_CNT_W'(DIV_NUM_W);
                    end
                end
                default: begin
                    done_next = 1'b1;
                end
            endcase
        end else if (busy_reg) begin
            // one restoring step: shift numerator bit into remainder
            if (!trial[33]) begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[32:0], quo_reg[DIV_NUM_W-1]};
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -64'(quo_next) : 64'(quo_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

`ifndef SYNTHESIS
    // a divide never reports done while still iterating
    assert property (@(posedge aclk) disable iff (!aresetn) busy_reg |-> !done_reg)
        else $error("arith: done while busy");
    // the counter is only nonzero during a divide
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0)
        else $error("arith: counter");
    // a divide that starts loads the counter with the full number of steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> cnt_reg == DIV_CNT_W'(DIV_NUM_W))
        else $error("arith: bad divide length");
`endif

endmodule

>>> src/kalman_angle_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_filter: two-state angle / gyro-bias Kalman filter
// Each input transaction runs ten multiplies and two divides (56 quotient steps
// each, none for a zero divisor) on the shared multiply/divide unit, then an output step.
// A new input is taken only in idle, after the previous output step.
// A result still waiting in the output register holds off the next input.
// Reset (aresetn low, synchronous) restores registers and filter state.
// ----------------------------------------------------------------------------
module kalman_angle_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // angle_measured [31:0], rate_measured [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // angle_filtered [31:0], rate_corrected [63:32]
);
    import kaf_pkg::*;

    logic [REG_W-1:0] qa_reg, qb_reg, rm_reg, dt_reg;

    kaf_state_t state_reg, state_next;
    logic              issued_reg, issued_next;
    logic signed [31:0] ang_reg, ang_next, bias_reg, bias_next;
    logic signed [31:0] p00_reg, p00_next, p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next, p11_reg, p11_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic signed [31:0] am_reg, am_next, rate_reg, rate_next;
    logic [63:0]        out_reg, out_next;
    logic               ov_reg, ov_next;
    logic signed [31:0] t0_reg, t1_reg, err_reg;

    kaf_req_t req;
    kaf_rsp_t rsp;

    logic signed [31:0] dsig, slope, neg11, err;
    logic signed [65:0] rw;

    kaf_arith u_arith (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= REG_W'(16777);
            qb_reg <= REG_W'(50332);
            rm_reg <= REG_W'(167772160);
            dt_reg <= REG_W'(83886);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NOISE_ANGLE: qa_reg <= cfg_data;
                REG_NOISE_BIAS:  qb_reg <= cfg_data;
                REG_MEASURE:     rm_reg <= cfg_data;
                REG_STEP_TIME:   dt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && (!ov_reg || m_tready);
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        ang_next = ang_reg; bias_next = bias_reg;
        p00_next = p00_reg; p01_next = p01_reg;
        p10_next = p10_reg; p11_next = p11_reg;
        k0_next = k0_reg; k1_next = k1_reg;
        am_next = am_reg; rate_next = rate_reg;
        out_next = out_reg;
        ov_next  = ov_reg && !m_tready;
        rw       = 66'(rsp.result);
        dsig  = sat32(66'(rate_reg) - 66'(bias_reg));
        slope = sat32(66'($signed({1'b0, qa_reg})) - 66'(p01_reg) - 66'(p10_reg));
        neg11 = sat32(-66'(p11_reg));
        err   = sat32(66'(am_reg) - 66'(ang_reg));
        req.start = 1'b0;
        req.op    = OP_MUL;
        req.a     = '0;
        req.b     = 33'($signed({1'b0, dt_reg}));
        case (state_reg)
            ST_PRED_A:   req.a = 33'(dsig);
            ST_PRED_P00: req.a = 33'(slope);
            ST_PRED_P01: req.a = 33'(neg11);
            ST_PRED_P11: req.a = 33'($signed({1'b0, qb_reg}));
            ST_DIV_K0: begin
                req.op = OP_DIV; req.a = 33'(p00_reg);
                req.b  = 33'(66'($signed({1'b0, rm_reg})) + 66'(p00_reg));
            end
            ST_DIV_K1: begin
                req.op = OP_DIV; req.a = 33'(p10_reg);
                req.b  = 33'(66'($signed({1'b0, rm_reg})) + 66'(p00_reg));
            end
            ST_UPD_00: begin req.a = 33'(k0_reg); req.b = 33'(t0_reg); end
            ST_UPD_01: begin req.a = 33'(k0_reg); req.b = 33'(t1_reg); end
            ST_UPD_10: begin req.a = 33'(k1_reg); req.b = 33'(t0_reg); end
            ST_UPD_11: begin req.a = 33'(k1_reg); req.b = 33'(t1_reg); end
            ST_UPD_A:  begin req.a = 33'(k0_reg); req.b = 33'(err_reg); end
            ST_UPD_B:  begin req.a = 33'(k1_reg); req.b = 33'(err_reg); end
            default: ;
        endcase
        if (state_reg != ST_IDLE && state_reg != ST_OUT && !issued_reg) begin
            req.start   = 1'b1;
            issued_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    am_next    = s_tdata[31:0];
                    rate_next  = s_tdata[63:32];
                    state_next = ST_PRED_A;
                end
            end
            ST_OUT: begin
                out_next   = {sat32(66'(rate_reg) - 66'(bias_reg)), ang_reg};
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                if (rsp.done && issued_reg) begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_PRED_A: begin
                            ang_next = sat32(66'(ang_reg) + rw); state_next = ST_PRED_P00;
                        end
                        ST_PRED_P00: begin
                            p00_next = sat32(66'(p00_reg) + rw); state_next = ST_PRED_P01;
                        end
                        ST_PRED_P01: begin
                            p01_next = sat32(66'(p01_reg) + rw);
                            p10_next = sat32(66'(p10_reg) + rw);
                            state_next = ST_PRED_P11;
                        end
                        ST_PRED_P11: begin
                            p11_next = sat32(66'(p11_reg) + rw); state_next = ST_DIV_K0;
                        end
                        ST_DIV_K0: begin k0_next = sat32(rw); state_next = ST_DIV_K1; end
                        ST_DIV_K1: begin k1_next = sat32(rw); state_next = ST_UPD_00; end
                        ST_UPD_00: begin
                            p00_next = sat32(66'(p00_reg) - rw); state_next = ST_UPD_01;
                        end
                        ST_UPD_01: begin
                            p01_next = sat32(66'(p01_reg) - rw); state_next = ST_UPD_10;
                        end
                        ST_UPD_10: begin
                            // k1 times the predicted p00
                            p10_next = sat32(66'(p10_reg) - rw); state_next = ST_UPD_11;
                        end
                        ST_UPD_11: begin
                            p11_next = sat32(66'(p11_reg) - rw); state_next = ST_UPD_A;
                        end
                        ST_UPD_A: begin
                            ang_next = sat32(66'(ang_reg) + rw); state_next = ST_UPD_B;
                        end
                        ST_UPD_B: begin
                            bias_next = sat32(66'(bias_reg) + rw); state_next = ST_OUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Predicted p00/p01 and the innovation, held for the correction steps
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV_K0) begin
            t0_reg  <= p00_reg;
            t1_reg  <= p01_reg;
            err_reg <= err;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            ov_reg     <= 1'b0;
            ang_reg    <= '0;
            bias_reg   <= '0;
            p00_reg    <= ONE_Q;
            p01_reg    <= '0;
            p10_reg    <= '0;
            p11_reg    <= ONE_Q;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            ov_reg     <= ov_next;
            ang_reg    <= ang_next;
            bias_reg   <= bias_next;
            p00_reg    <= p00_next;
            p01_reg    <= p01_next;
            p10_reg    <= p10_next;
            p11_reg    <= p11_next;
        end
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        am_reg   <= am_next;
        rate_reg <= rate_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    // an accepted input starts the prediction sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_PRED_A)
        else $error("top: accept did not start sequence");
    // the output step leaves a valid result in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == ST_OUT |-> m_tvalid)
        else $error("top: result lost");
    // no new input while a sequence runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("top: ready during work");
`endif

endmodule

>>> tb/kaf_checker.sv
// ----------------------------------------------------------------------------
// kaf_checker: result predictor and scoreboard for kalman_angle_filter
// Tracks register writes, computes the filtered angle and corrected rate for
// every accepted input transaction, and compares output transactions in order.
// ----------------------------------------------------------------------------
module kaf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // angle_measured [31:0], rate_measured [63:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // angle_filtered [31:0], rate_corrected [63:32]
    output int          errors,
    output int          pending
);
    import kaf_pkg::*;

    typedef struct packed {
        logic signed [31:0] rate_corr;
        logic signed [31:0] angle_filt;
    } kaf_result_t;

    kaf_result_t expected_results[$];

    // Register shadow
    longint q_angle, q_bias, r_meas, dt;
    // Filter state shadow
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rounded Q product, halves toward plus infinity
    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint kgain(longint num, longint den);
        if (den == 0) return 0;
        return clamp32((num <<< FRAC_BITS) / den);
    endfunction

    task automatic reset_model();
        q_angle = 16777; q_bias = 50332; r_meas = 167772160; dt = 83886;
        est_angle = 0; est_bias = 0;
        p_aa = longint'(ONE_Q); p_ab = 0; p_ba = 0; p_bb = longint'(ONE_Q);
    endtask

    // One filter step: predict, then correct
    function automatic kaf_result_t filter_step(longint am, longint rm);
        longint d, slope, neg_bb, innov, e, k0, k1, n00, n01, n10, n11;
        kaf_result_t res;
        d = clamp32(rm - est_bias);
        est_angle = clamp32(est_angle + qmul(d, dt));
        slope = clamp32(q_angle - p_ab - p_ba);
        neg_bb = clamp32(-p_bb);
        n00 = clamp32(p_aa + qmul(slope, dt));
        n01 = clamp32(p_ab + qmul(neg_bb, dt));
        n10 = clamp32(p_ba + qmul(neg_bb, dt));
        n11 = clamp32(p_bb + qmul(q_bias, dt));
        innov = clamp32(am - est_angle);
        e = r_meas + n00;
        k0 = kgain(n00, e);
        k1 = kgain(n10, e);
        p_aa = clamp32(n00 - qmul(k0, n00));
        p_ab = clamp32(n01 - qmul(k0, n01));
        p_ba = clamp32(n10 - qmul(k1, n00));
        p_bb = clamp32(n11 - qmul(k1, n01));
        est_angle = clamp32(est_angle + qmul(k0, innov));
        est_bias = clamp32(est_bias + qmul(k1, innov));
        res.angle_filt = est_angle[31:0];
        res.rate_corr = 32'(clamp32(rm - est_bias));
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %08h expected %08h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    initial begin
        errors = 0;
        reset_model();
    end

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        kaf_result_t exp;
        if (!aresetn) begin
            reset_model();
            expected_results.delete();
        end else begin
            // Register writes land before any transaction of the same edge
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NOISE_ANGLE: q_angle = longint'(cfg_data);
                    REG_NOISE_BIAS:  q_bias  = longint'(cfg_data);
                    REG_MEASURE:     r_meas  = longint'(cfg_data);
                    REG_STEP_TIME:   dt      = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(filter_step(
                    longint'($signed(s_tdata[31:0])), longint'($signed(s_tdata[63:32]))));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected output", m_tdata[31:0], 32'h0);
                end else begin
                    exp = expected_results.pop_front();
                    if (m_tdata[31:0] !== exp.angle_filt)
                        report_mismatch("angle_filtered", m_tdata[31:0], exp.angle_filt);
                    if (m_tdata[63:32] !== exp.rate_corr)
                        report_mismatch("rate_corrected", m_tdata[63:32], exp.rate_corr);
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for kalman_angle_filter
// Runs phases of register settings with directed and random measurements
// under varying sender gaps and receiver stalls; a checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import kaf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int errors, pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    kalman_angle_filter dut (.*);

    kaf_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
            repeat (800) @(posedge aclk);
            hold_off = 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering and wait until the filter has drained before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_regs(logic [30:0] qa, logic [30:0] qb, logic [30:0] rm,
                            logic [30:0] st);
        drain();
        write_reg(REG_NOISE_ANGLE, qa);
        write_reg(REG_NOISE_BIAS, qb);
        write_reg(REG_MEASURE, rm);
        write_reg(REG_STEP_TIME, st);
    endtask

    task automatic send_meas(logic [31:0] ang, logic [31:0] rate);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rate, ang};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(180 << 16)) - (90 << 16));
            2: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic logic [30:0] rand_reg();
        case ($urandom_range(4))
            0: return 31'h0;
            1: return 31'h7fffffff;
            2: return 31'($urandom());
            default: return 31'($urandom_range(1 << 25));
        endcase
    endfunction

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int phase;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes at reset settings
        send_meas(32'h0, 32'h0);
        send_meas(32'h7fffffff, 32'h7fffffff);
        send_meas(32'h80000000, 32'h80000000);
        send_meas(32'h7fffffff, 32'h80000000);
        send_meas(32'h80000000, 32'h7fffffff);
        send_meas(32'hffffffff, 32'h00000001);
        // Zero divisor: no measurement noise and no time step drive E to zero
        set_regs(31'd16777, 31'd50332, 31'd0, 31'd0);
        repeat (4) send_meas(32'h0010_0000, 32'hfff0_0000);
        send_meas(32'h7fffffff, 32'h80000000);
        // Negative divisor: huge step with no measurement noise
        set_regs(31'd0, 31'h7fffffff, 31'd0, 31'h7fffffff);
        repeat (4) send_meas(32'h0005_0000, 32'h7fffffff);
        // All registers at their maximum
        set_regs(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        repeat (4) send_meas(32'h80000000, 32'h7fffffff);

        // Random phases with changing settings and flow control
        for (phase = 0; phase < 12; phase++) begin
            if (phase % 3 == 0)
                set_regs(31'd16777, 31'd50332, 31'd167772160, 31'd83886);
            else
                set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg());
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (phase == 4) hold_off = 1'b1;
            repeat (140) send_meas(rand_field(), rand_field());
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
src/kaf_pkg.sv
src/kaf_arith.sv
src/kalman_angle_filter.sv
tb/kaf_checker.sv
tb/tb.sv
